### sv/strict_priority_packet_queue_assert.svh
// Assertion macros used by the strict priority packet queue controller.
// Included by files that check their own control logic.
`ifndef STRICT_PRIORITY_PACKET_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_PACKET_QUEUE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the following cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/spq_pkg.sv
// Shared constants and types of the strict priority packet queue.
// No dependencies.
package spq_pkg;
  localparam int PriorityLevelsDef = 8;
  localparam int QueueDepthDef = 16;
  localparam int MaxBurstDef = 64;
  localparam int IdW = 16;
  localparam int PrioW = 3;
  localparam int CountW = 7;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic thin_step; // copy one entry during thinning
    logic thin_done; // set new length after thinning
    logic append;    // write the received id
    logic scan_down; // move the send level down by one
    logic pop;       // read head entry into the output stage
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_send;
    logic lvl_valid;  // received level exists
    logic full;       // received level queue is full
    logic thin_last;  // all thinning copies are written
    logic lvl_empty;  // current send level is empty
    logic lvl_zero;   // current send level is zero
    logic cnt_zero;   // send budget used up
    logic out_busy;   // output stage holds, or is about to load, an unaccepted item
  } spq_stat_t;
endpackage

### sv/spq_ctrl.sv
// Controller state machine of the strict priority packet queue.
// Depends on spq_pkg and the assertion header.
`include "strict_priority_packet_queue_assert.svh"
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_THIN   = 6'b000100,
    S_APPEND = 6'b001000,
    S_SEND   = 6'b010000,
    S_WAIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_send) state_next = S_SEND;
        else if (!stat.lvl_valid) state_next = S_IDLE;
        else if (stat.full) state_next = S_THIN;
        else state_next = S_APPEND;
      end
      S_THIN: begin
        if (stat.thin_last) begin
          cmd.thin_done = 1'b1;
          state_next = S_APPEND;
        end else begin
          cmd.thin_step = 1'b1;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_IDLE;
      end
      S_SEND: begin
        if (stat.cnt_zero) begin
          state_next = S_WAIT;
        end else if (!stat.lvl_empty) begin
          if (!stat.out_busy) cmd.pop = 1'b1;
        end else if (stat.lvl_zero) begin
          state_next = S_WAIT;
        end else begin
          cmd.scan_down = 1'b1;
        end
      end
      S_WAIT: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `SPQ_ASSERT_IMP(a_one_hot, 1'b1, $onehot(state), "state not one-hot")
  `SPQ_ASSERT_IMP(a_pop_free, cmd.pop, !stat.out_busy, "pop while output busy")
  `SPQ_ASSERT_NEXT(a_load_decode, cmd.load, state == S_DECODE, "load not followed by decode")
endmodule

### sv/spq_datapath.sv
// Datapath of the strict priority packet queue: per-level FIFO memory,
// head and length registers, thinning copy and output register. Uses spq_pkg.
module spq_datapath import spq_pkg::*; #(
  parameter int PRIORITY_LEVELS = PriorityLevelsDef,
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int MAX_BURST = MaxBurstDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_op,
  input  logic [IdW-1:0]   in_id,
  input  logic [PrioW-1:0] in_prio,
  input  logic [CountW-1:0] in_count,
  input  spq_cmd_t         cmd,
  output spq_stat_t        stat,
  output logic [IdW-1:0]   out_id,
  output logic [PrioW-1:0] out_prio,
  output logic             out_last,
  output logic             out_valid,
  input  logic             out_ready
);
  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int DW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = LW + DW;

  // Each level owns a block of 2**DW words, addressed as {level, slot}.
  logic [IdW-1:0] mem [PRIORITY_LEVELS * (2 ** DW)];
  logic [DW-1:0] head [PRIORITY_LEVELS];
  logic [NW-1:0] len [PRIORITY_LEVELS];

  logic op;
  logic [IdW-1:0] id;
  logic [PrioW-1:0] prio;
  logic [CountW-1:0] cnt;
  logic [LW-1:0] lvl;
  logic [NW-1:0] k;
  // Thinning pipeline: read stage then write stage.
  logic rd_pend;
  logic [NW-1:0] wk;
  logic [IdW-1:0] rd_data;
  // Send pop: the id is read into the output register at the pop; valid, priority and last follow next cycle.
  logic pop_pend, pop_last;
  logic [LW-1:0] pop_lvl;
  // True when no packets remain below the popped level; read while pop_pend is set.
  logic lower_empty;

  function automatic logic [DW-1:0] slot(input logic [DW-1:0] h, input logic [NW:0] off);
    logic [NW:0] s;
    s = {{(NW+1-DW){1'b0}}, h} + off;
    if (s >= (NW+1)'(QUEUE_DEPTH)) s = s - (NW+1)'(QUEUE_DEPTH);
    if (s >= (NW+1)'(QUEUE_DEPTH)) s = s - (NW+1)'(QUEUE_DEPTH);
    return s[DW-1:0];
  endfunction

  logic [NW-1:0] kept;
  logic [NW-1:0] cur_len;
  logic [DW-1:0] cur_head;
  logic [CountW-1:0] cnt_next;
  assign cur_len = len[lvl];
  assign cur_head = head[lvl];
  assign kept = NW'(({1'b0, cur_len} + 1'b1) >> 1);

  always_comb begin
    cnt_next = cnt - 1'b1;
    stat.is_send = op == OP_SEND;
    stat.lvl_valid = {{(32-PrioW){1'b0}}, prio} < PRIORITY_LEVELS;
    stat.full = cur_len >= NW'(QUEUE_DEPTH);
    stat.thin_last = (k >= kept) && !rd_pend;
    stat.lvl_empty = cur_len == '0;
    stat.lvl_zero = lvl == '0;
    stat.cnt_zero = cnt == '0;
    stat.out_busy = pop_pend || (out_valid && !out_ready);
  end

  always_comb begin
    lower_empty = 1'b1;
    for (int i = 0; i < PRIORITY_LEVELS; i++)
      if (LW'(i) < pop_lvl && len[i] != '0) lower_empty = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      id <= in_id;
      prio <= in_prio;
      cnt <= (in_count > CountW'(MAX_BURST)) ? CountW'(MAX_BURST) : in_count;
      k <= NW'(1);
      if (in_op == OP_SEND) lvl <= LW'(PRIORITY_LEVELS - 1);
      else lvl <= LW'(in_prio);
    end
    if (cmd.scan_down) lvl <= lvl - 1'b1;
    rd_pend <= 1'b0;
    if (cmd.thin_step) begin
      if (k < kept) begin
        rd_data <= mem[{lvl, slot(cur_head, {k, 1'b0})}];
        wk <= k;
        rd_pend <= 1'b1;
        k <= k + 1'b1;
      end
    end
    if (rd_pend) mem[{lvl, slot(cur_head, {1'b0, wk})}] <= rd_data;
    if (cmd.append) mem[{lvl, slot(cur_head, {1'b0, cur_len})}] <= id;
    if (cmd.pop) begin
      out_id <= mem[AW'({lvl, cur_head})];
      pop_lvl <= lvl;
      // Last when budget ends, or no entries remain at this or lower levels.
      pop_last <= cnt_next == '0;
      cnt <= cnt_next;
    end
    if (pop_pend) begin
      out_prio <= PrioW'(pop_lvl);
      out_last <= pop_last || (cur_len == '0 && lower_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pop_pend <= 1'b0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head[i] <= '0;
        len[i] <= '0;
      end
    end else begin
      pop_pend <= cmd.pop;
      if (pop_pend) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.thin_done) len[lvl] <= kept;
      if (cmd.append) len[lvl] <= cur_len + 1'b1;
      if (cmd.pop) begin
        head[lvl] <= slot(cur_head, (NW+1)'(1));
        len[lvl] <= cur_len - 1'b1;
      end
    end
  end
endmodule

### sv/strict_priority_packet_queue.sv
// Strict priority packet queue, one FIFO per level.
// Input channel s_axis: one item is a receive (append an id) or a send request.
// Output channel m_axis: one item per sent packet, tlast on the final one.
// A receive to an existing level passes through decode and append; when
// the level queue is full it is thinned first, one entry copy per cycle
// through the memory. A send reads each emitted packet from memory into
// the output register and steps down one level at a time past empty levels.
// One item is worked on at a time; s_axis_tready is high only when idle.
// Reset clears all levels to empty and drops any pending output item.
// When the receiver stalls, the output register holds its item and the
// send pauses; no packet is lost. Memory contents need no clearing.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module strict_priority_packet_queue import spq_pkg::*; #(
  parameter int PRIORITY_LEVELS = PriorityLevelsDef,
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int MAX_BURST = MaxBurstDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[0], packet_id[16:1], priority_req[19:17], send_count[26:20], zero pad
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sent_id[15:0], sent_priority[18:16], zero pad
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  spq_cmd_t cmd;
  spq_stat_t stat;
  logic [IdW-1:0] out_id;
  logic [PrioW-1:0] out_prio;

  spq_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .stat, .cmd
  );

  spq_datapath #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_BURST(MAX_BURST)
  ) u_dp (
    .clk, .rst,
    .in_op(s_axis_tdata[0]), .in_id(s_axis_tdata[16:1]),
    .in_prio(s_axis_tdata[19:17]), .in_count(s_axis_tdata[26:20]),
    .cmd, .stat,
    .out_id, .out_prio, .out_last(m_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
  );

  assign m_axis_tdata = {5'b0, out_prio, out_id};
endmodule

### bench/testbench.sv
// Self-checking bench for the strict priority packet queue.
// Predicts each sent packet from a local copy of the per-level FIFOs.
// Depends on spq_pkg and strict_priority_packet_queue.
module testbench;
  import spq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Levels = PriorityLevelsDef;
  localparam int Depth = QueueDepthDef;
  localparam int Burst = MaxBurstDef;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [PrioW-1:0] prio;
    logic last;
  } sent_pkt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;

  strict_priority_packet_queue dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #1 clk = ~clk;

  // Local FIFOs per level, oldest first.
  logic [IdW-1:0] level_fifo [Levels][$];
  sent_pkt_t pending_sends[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit drained = 1'b0;

  // Applies one item to the local FIFOs and queues the packets it sends.
  task automatic predict_item(logic op, logic [IdW-1:0] pid, logic [PrioW-1:0] lvl,
                              logic [CountW-1:0] cnt);
    int budget;
    int sent;
    logic [IdW-1:0] kept[$];
    sent_pkt_t pkt;
    if (op == OP_RECEIVE) begin
      if (level_fifo[lvl].size() >= Depth) begin
        kept = {};
        for (int k = 0; k < level_fifo[lvl].size(); k += 2) kept.push_back(level_fifo[lvl][k]);
        level_fifo[lvl] = kept;
      end
      level_fifo[lvl].push_back(pid);
    end else begin
      budget = (cnt > Burst) ? Burst : cnt;
      sent = 0;
      for (int l = Levels - 1; l >= 0 && sent < budget; l--) begin
        while (level_fifo[l].size() > 0 && sent < budget) begin
          pkt.id = level_fifo[l].pop_front();
          pkt.prio = l[PrioW-1:0];
          pkt.last = 1'b0;
          pending_sends.push_back(pkt);
          sent++;
        end
      end
      if (sent > 0) pending_sends[$].last = 1'b1;
    end
  endtask

  // The valid line stays high between items sent back to back; it drops only
  // during an idle burst or when the sender waits for the results.
  task automatic send_item(logic op, logic [IdW-1:0] pid, logic [PrioW-1:0] lvl,
                           logic [CountW-1:0] cnt);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, cnt, lvl, pid, op};
    do @(posedge clk); while (!s_axis_tready);
    predict_item(op, pid, lvl, cnt);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_sends.size() > 0) @(posedge clk);
  endtask

  task automatic receive(logic [PrioW-1:0] lvl);
    send_item(OP_RECEIVE, IdW'($urandom), lvl, CountW'($urandom));
  endtask

  task automatic request_send(int cnt);
    send_item(OP_SEND, IdW'($urandom), PrioW'($urandom), CountW'(cnt));
  endtask

  // Edge cases: empty send, zero count, extreme ids, overflow count.
  task automatic test_directed();
    request_send(5);
    send_item(OP_RECEIVE, 16'h0000, 3'd0, 7'h7f);
    send_item(OP_RECEIVE, 16'hffff, 3'd7, 7'h00);
    send_item(OP_RECEIVE, 16'h5a5a, 3'd7, 7'h40);
    request_send(0);
    send_item(OP_SEND, 16'hffff, 3'd7, 7'd1);
    request_send(127);
    request_send(3);
    for (int i = 0; i < 8; i++) receive(PrioW'(i));
    request_send(64);
    wait_drained();
  endtask

  // Overflows two levels so that both are thinned, then drains them.
  task automatic test_thinning();
    for (int i = 0; i < 2 * Depth + 3; i++) receive(3'd5);
    for (int i = 0; i < Depth + 2; i++) receive(3'd2);
    request_send(100);
    wait_drained();
  endtask

  // Mostly receives spread over levels, with sends of mixed counts.
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        request_send($urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                               : $urandom_range(1, 12));
      else
        receive(PrioW'($urandom));
    end
  endtask

  // Receiver side with random stall bursts.
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_axis_tready <= !rst;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compares each accepted packet with the oldest prediction.
  always @(posedge clk) begin
    sent_pkt_t got;
    sent_pkt_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.id = m_axis_tdata[15:0];
      got.prio = m_axis_tdata[18:16];
      got.last = m_axis_tlast;
      if (pending_sends.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected packet id %h prio %0d", got.id, got.prio);
      end else begin
        want = pending_sends.pop_front();
        if (got !== want || m_axis_tdata[23:19] !== 5'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected id %h prio %0d last %b, got id %h prio %0d last %b",
                     want.id, want.prio, want.last, got.id, got.prio, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thinning();
    test_random(220);
    wait_drained();
    test_random(60);
    quiet = 1'b1;
    test_random(40);
    request_send(127);
    request_send(127);
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_sends.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
